// File: sv/wvwm_pkg.sv
// Package: shared types, codes and constants of the write volume window monitor.
`default_nettype none
package wvwm_pkg;

   localparam int LOG_DEPTH_DEFAULT  = 64;
   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH        = 2;

   localparam int COMMAND_W   = 3;
   localparam int BYTES_W     = 64;
   localparam int COUNT_W     = 64;
   localparam int POSITION_W  = 6;
   localparam int AGE_W       = 32;
   localparam int REASON_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int THRESHOLD_W = 20;
   localparam int WINDOW_W    = 24;
   localparam int MIB_SHIFT   = 20;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(100);
   localparam logic [WINDOW_W-1:0]    WINDOW_RESET    = WINDOW_W'(60000);

   typedef enum logic [COMMAND_W-1:0] {
      CMD_TICK     = 3'd0,
      CMD_WRITE    = 3'd1,
      CMD_SIMULATE = 3'd2,
      CMD_READ     = 3'd3,
      CMD_CLEAR    = 3'd4
   } command_type;

   typedef enum logic [REASON_W-1:0] {
      REASON_REMOVABLE = 2'd0,
      REASON_TEST      = 2'd1,
      REASON_SIMULATE  = 2'd2
   } reason_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALL_DEVICES = 2'd0,
      CSR_THRESHOLD   = 2'd1,
      CSR_WINDOW      = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_EVENT,
      OP_READ,
      OP_CLEAR,
      OP_NOP
   } op_kind_type;

   typedef struct packed {
      op_kind_type             kind;
      reason_type              reason;
      logic [BYTES_W-1:0]      bytes;
      logic [POSITION_W-1:0]   position;
   } op_type;

   typedef struct packed {
      logic [THRESHOLD_W-1:0] threshold_megabytes;
      logic [WINDOW_W-1:0]    window_ticks;
   } cfg_type;

endpackage
`default_nettype wire

// File: sv/write_volume_window_monitor.sv
// Top level of the write volume window monitor.
//
//   channel   direction  handshake                      payload
//   req_      in         req_valid / req_ready          command, byte count, disk flags, position
//   rsp_      out        rsp_valid / rsp_ready          flags, totals, log fill, log entry
//   csr_      in         csr_write_enable (no wait)     register index, write data
//
// One item per cycle sustained while results are taken; a result turns valid once its item has
// passed the queue slot register and then the back end's result register.
// The rate is set by the back end, which retires one queued item per cycle, unless a stalled
// result blocks it, through its state update and a single-port read of the log ring.
// Synchronous reset clears statistics, time, window and queue; the ring needs no clearing.
// A stalled result holds in the output register while the two-entry queue takes items until full.
`default_nettype none
module write_volume_window_monitor #(
   parameter int LOG_DEPTH  = wvwm_pkg::LOG_DEPTH_DEFAULT,
   parameter int TIME_WIDTH = wvwm_pkg::TIME_WIDTH_DEFAULT,
   localparam int FILL_W    = $clog2(LOG_DEPTH + 1)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [wvwm_pkg::COMMAND_W-1:0]       req_command,
   input  wire logic [wvwm_pkg::BYTES_W-1:0]         req_byte_count,
   input  wire logic                                 req_has_disk,
   input  wire logic                                 req_removable,
   input  wire logic [wvwm_pkg::POSITION_W-1:0]      req_position,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_logged,
   output logic                                      rsp_alert,
   output logic [wvwm_pkg::COUNT_W-1:0]              rsp_transfers,
   output logic [wvwm_pkg::COUNT_W-1:0]              rsp_total_bytes,
   output logic [wvwm_pkg::COUNT_W-1:0]              rsp_alerts,
   output logic [FILL_W-1:0]                         rsp_log_fill,
   output logic                                      rsp_entry_valid,
   output logic [wvwm_pkg::COUNT_W-1:0]              rsp_entry_id,
   output logic [wvwm_pkg::BYTES_W-1:0]              rsp_entry_bytes,
   output logic [wvwm_pkg::AGE_W-1:0]                rsp_entry_age,
   output logic [wvwm_pkg::REASON_W-1:0]             rsp_entry_reason,
   input  wire logic                                 csr_write_enable,
   input  wire logic [wvwm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [wvwm_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   wvwm_pkg::op_type   front_op;
   wvwm_pkg::op_type   head_op;
   wvwm_pkg::cfg_type  cfg;
   logic               q_not_full;
   logic               q_not_empty;
   logic               q_pop;

   assign req_ready = q_not_full;

   wvwm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_byte_count   (req_byte_count),
      .req_has_disk     (req_has_disk),
      .req_removable    (req_removable),
      .req_position     (req_position),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .op               (front_op),
      .cfg              (cfg)
   );

   wvwm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && q_not_full),
      .push_op   (front_op),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .head_op   (head_op),
      .not_empty (q_not_empty)
   );

   wvwm_back #(
      .LOG_DEPTH  (LOG_DEPTH),
      .TIME_WIDTH (TIME_WIDTH),
      .FILL_W     (FILL_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_op             (head_op),
      .q_valid          (q_not_empty),
      .q_pop            (q_pop),
      .cfg              (cfg),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_logged       (rsp_logged),
      .rsp_alert        (rsp_alert),
      .rsp_transfers    (rsp_transfers),
      .rsp_total_bytes  (rsp_total_bytes),
      .rsp_alerts       (rsp_alerts),
      .rsp_log_fill     (rsp_log_fill),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_entry_id     (rsp_entry_id),
      .rsp_entry_bytes  (rsp_entry_bytes),
      .rsp_entry_age    (rsp_entry_age),
      .rsp_entry_reason (rsp_entry_reason)
   );

endmodule
`default_nettype wire

// File: sv/wvwm_front.sv
// Front end: configuration registers and classification of incoming items.
`default_nettype none
module wvwm_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [wvwm_pkg::COMMAND_W-1:0]       req_command,
   input  wire logic [wvwm_pkg::BYTES_W-1:0]         req_byte_count,
   input  wire logic                                 req_has_disk,
   input  wire logic                                 req_removable,
   input  wire logic [wvwm_pkg::POSITION_W-1:0]      req_position,
   input  wire logic                                 csr_write_enable,
   input  wire logic [wvwm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [wvwm_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output wvwm_pkg::op_type                          op,
   output wvwm_pkg::cfg_type                         cfg
);

   logic                                all_devices_ff;
   logic                                all_devices_in;
   logic [wvwm_pkg::THRESHOLD_W-1:0]    threshold_ff;
   logic [wvwm_pkg::THRESHOLD_W-1:0]    threshold_in;
   logic [wvwm_pkg::WINDOW_W-1:0]       window_ff;
   logic [wvwm_pkg::WINDOW_W-1:0]       window_in;

   always_comb begin
      all_devices_in = all_devices_ff;
      threshold_in   = threshold_ff;
      window_in      = window_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            wvwm_pkg::CSR_ALL_DEVICES: all_devices_in = csr_write_data[0];
            wvwm_pkg::CSR_THRESHOLD:   threshold_in = csr_write_data[wvwm_pkg::THRESHOLD_W-1:0];
            wvwm_pkg::CSR_WINDOW:      window_in = csr_write_data[wvwm_pkg::WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         all_devices_ff <= 1'b0;
         threshold_ff   <= wvwm_pkg::THRESHOLD_RESET;
         window_ff      <= wvwm_pkg::WINDOW_RESET;
      end else begin
         all_devices_ff <= all_devices_in;
         threshold_ff   <= threshold_in;
         window_ff      <= window_in;
      end
   end

   assign cfg.threshold_megabytes = threshold_ff;
   assign cfg.window_ticks        = window_ff;

   always_comb begin
      op.kind     = wvwm_pkg::OP_NOP;
      op.reason   = wvwm_pkg::REASON_SIMULATE;
      op.bytes    = req_byte_count;
      op.position = req_position;
      unique case (req_command)
         wvwm_pkg::CMD_TICK: op.kind = wvwm_pkg::OP_TICK;
         wvwm_pkg::CMD_WRITE: begin
            // zero-byte, diskless or filtered non-removable writes are dropped
            if ((req_byte_count != '0) && req_has_disk && (all_devices_ff || req_removable)) begin
               op.kind   = wvwm_pkg::OP_EVENT;
               op.reason = req_removable ? wvwm_pkg::REASON_REMOVABLE
                                         : wvwm_pkg::REASON_TEST;
            end
         end
         wvwm_pkg::CMD_SIMULATE: op.kind = wvwm_pkg::OP_EVENT;
         wvwm_pkg::CMD_READ:     op.kind = wvwm_pkg::OP_READ;
         wvwm_pkg::CMD_CLEAR:    op.kind = wvwm_pkg::OP_CLEAR;
         default:                op.kind = wvwm_pkg::OP_NOP;
      endcase
   end

endmodule
`default_nettype wire

// File: sv/wvwm_queue.sv
// Short FIFO of classified items between front and back.
`default_nettype none
module wvwm_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wvwm_pkg::op_type   push_op,
   output logic               not_full,
   input  wire logic          pop,
   output wvwm_pkg::op_type   head_op,
   output logic               not_empty
);

   localparam int DEPTH = wvwm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wvwm_pkg::op_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_op   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

// File: sv/wvwm_back.sv
// Back end: statistics, window accumulator, event log ring and result register.
`default_nettype none
module wvwm_back #(
   parameter int LOG_DEPTH  = wvwm_pkg::LOG_DEPTH_DEFAULT,
   parameter int TIME_WIDTH = wvwm_pkg::TIME_WIDTH_DEFAULT,
   parameter int FILL_W     = $clog2(wvwm_pkg::LOG_DEPTH_DEFAULT + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wvwm_pkg::op_type                       q_op,
   input  wire logic                              q_valid,
   output logic                                   q_pop,
   input  wvwm_pkg::cfg_type                      cfg,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_logged,
   output logic                                   rsp_alert,
   output logic [wvwm_pkg::COUNT_W-1:0]           rsp_transfers,
   output logic [wvwm_pkg::COUNT_W-1:0]           rsp_total_bytes,
   output logic [wvwm_pkg::COUNT_W-1:0]           rsp_alerts,
   output logic [FILL_W-1:0]                      rsp_log_fill,
   output logic                                   rsp_entry_valid,
   output logic [wvwm_pkg::COUNT_W-1:0]           rsp_entry_id,
   output logic [wvwm_pkg::BYTES_W-1:0]           rsp_entry_bytes,
   output logic [wvwm_pkg::AGE_W-1:0]             rsp_entry_age,
   output logic [wvwm_pkg::REASON_W-1:0]          rsp_entry_reason
);

   localparam int AW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int PW   = wvwm_pkg::POSITION_W;
   localparam int SW   = ((AW > PW) ? AW : PW) + 1;
   localparam int CW   = (FILL_W > PW) ? FILL_W : PW;
   localparam int TW   = TIME_WIDTH;
   localparam int WW   = (TW > wvwm_pkg::WINDOW_W) ? TW : wvwm_pkg::WINDOW_W;
   localparam int AGEW = (TW > wvwm_pkg::AGE_W) ? TW : wvwm_pkg::AGE_W;
   localparam int BW   = wvwm_pkg::BYTES_W;
   localparam int NW   = wvwm_pkg::COUNT_W;

   // architectural state
   logic [TW-1:0]      now_ff, now_in;
   logic [NW-1:0]      transfers_ff, transfers_in;
   logic [NW-1:0]      byte_total_ff, byte_total_in;
   logic [NW-1:0]      alerts_ff, alerts_in;
   logic [TW-1:0]      wstart_ff, wstart_in;
   logic [BW-1:0]      wsum_ff, wsum_in;
   logic [AW-1:0]      next_ff, next_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   // log ring
   logic [NW-1:0]                  ring_id_mem     [LOG_DEPTH];
   logic [BW-1:0]                  ring_bytes_mem  [LOG_DEPTH];
   logic [TW-1:0]                  ring_time_mem   [LOG_DEPTH];
   logic [wvwm_pkg::REASON_W-1:0]  ring_reason_mem [LOG_DEPTH];
   logic [NW-1:0]                  rd_id_ff;
   logic [BW-1:0]                  rd_bytes_ff;
   logic [TW-1:0]                  rd_time_ff;
   logic [wvwm_pkg::REASON_W-1:0]  rd_reason_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               logged_ff, logged_in;
   logic               alert_ff, alert_in;
   logic               entry_valid_ff, entry_valid_in;
   logic [TW-1:0]      rsp_now_ff;

   logic               exec;
   logic               wr_en;
   logic [TW-1:0]      deadline;
   logic [TW-1:0]      deadline_gap;
   logic               expired;
   logic [BW-1:0]      sum_base;
   logic [BW:0]        sum_wide;
   logic [BW-1:0]      sum_sat;
   logic [BW-1:0]      limit;
   logic               hit;
   logic [AW-1:0]      oldest;
   logic [SW-1:0]      idx_wide;
   logic [SW-1:0]      idx_wrap;
   logic [AW-1:0]      rd_idx;
   logic               pos_in_range;
   logic [TW-1:0]      age_diff;
   logic [AGEW-1:0]    age_ext;

   assign exec  = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop = exec;

   // window expiry: now strictly after start + window length, modulo time width
   assign deadline     = TW'(WW'(wstart_ff) + WW'(cfg.window_ticks));
   assign deadline_gap = deadline - now_ff;
   assign expired      = deadline_gap[TW-1];

   assign sum_base = expired ? '0 : wsum_ff;
   assign sum_wide = {1'b0, sum_base} + {1'b0, q_op.bytes};
   assign sum_sat  = sum_wide[BW] ? '1 : sum_wide[BW-1:0];
   assign limit    = BW'({cfg.threshold_megabytes, {wvwm_pkg::MIB_SHIFT{1'b0}}});
   assign hit      = (cfg.threshold_megabytes != '0) && (sum_sat >= limit);

   // until the ring wraps the oldest entry sits at index zero
   assign oldest       = (fill_ff < FILL_W'(LOG_DEPTH)) ? '0 : next_ff;
   assign idx_wide     = SW'(oldest) + SW'(q_op.position);
   assign idx_wrap     = (idx_wide >= SW'(LOG_DEPTH)) ? idx_wide - SW'(LOG_DEPTH) : idx_wide;
   assign rd_idx       = idx_wrap[AW-1:0];
   assign pos_in_range = CW'(q_op.position) < CW'(fill_ff);

   always_comb begin
      now_in         = now_ff;
      transfers_in   = transfers_ff;
      byte_total_in  = byte_total_ff;
      alerts_in      = alerts_ff;
      wstart_in      = wstart_ff;
      wsum_in        = wsum_ff;
      next_in        = next_ff;
      fill_in        = fill_ff;
      logged_in      = 1'b0;
      alert_in       = 1'b0;
      entry_valid_in = 1'b0;
      wr_en          = 1'b0;
      if (exec) begin
         unique case (q_op.kind)
            wvwm_pkg::OP_TICK: now_in = now_ff + 1'b1;
            wvwm_pkg::OP_EVENT: begin
               logged_in     = 1'b1;
               wr_en         = 1'b1;
               transfers_in  = transfers_ff + 1'b1;
               byte_total_in = byte_total_ff + q_op.bytes;
               next_in       = (next_ff == AW'(LOG_DEPTH - 1)) ? '0 : next_ff + 1'b1;
               if (fill_ff < FILL_W'(LOG_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (hit) begin
                  alert_in  = 1'b1;
                  alerts_in = alerts_ff + 1'b1;
                  wstart_in = now_ff;
                  wsum_in   = '0;
               end else begin
                  wstart_in = expired ? now_ff : wstart_ff;
                  wsum_in   = sum_sat;
               end
            end
            wvwm_pkg::OP_READ: entry_valid_in = pos_in_range;
            wvwm_pkg::OP_CLEAR: begin
               transfers_in  = '0;
               byte_total_in = '0;
               alerts_in     = '0;
               next_in       = '0;
               fill_in       = '0;
               wstart_in     = now_ff;
               wsum_in       = '0;
            end
            wvwm_pkg::OP_NOP: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         transfers_ff  <= '0;
         byte_total_ff <= '0;
         alerts_ff     <= '0;
         wstart_ff     <= '0;
         wsum_ff       <= '0;
         next_ff       <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         now_ff        <= now_in;
         transfers_ff  <= transfers_in;
         byte_total_ff <= byte_total_in;
         alerts_ff     <= alerts_in;
         wstart_ff     <= wstart_in;
         wsum_ff       <= wsum_in;
         next_ff       <= next_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, loaded with the state after the item
   always_ff @(posedge clock) begin
      if (exec) begin
         logged_ff      <= logged_in;
         alert_ff       <= alert_in;
         entry_valid_ff <= entry_valid_in;
         rsp_now_ff     <= now_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_id_mem[next_ff]     <= transfers_in;
         ring_bytes_mem[next_ff]  <= q_op.bytes;
         ring_time_mem[next_ff]   <= now_ff;
         ring_reason_mem[next_ff] <= q_op.reason;
      end
      if (exec) begin
         rd_id_ff     <= ring_id_mem[rd_idx];
         rd_bytes_ff  <= ring_bytes_mem[rd_idx];
         rd_time_ff   <= ring_time_mem[rd_idx];
         rd_reason_ff <= ring_reason_mem[rd_idx];
      end
   end

   assign age_diff = rsp_now_ff - rd_time_ff;
   assign age_ext  = AGEW'(age_diff);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_logged       = logged_ff;
   assign rsp_alert        = alert_ff;
   assign rsp_transfers    = transfers_ff;
   assign rsp_total_bytes  = byte_total_ff;
   assign rsp_alerts       = alerts_ff;
   assign rsp_log_fill     = fill_ff;
   assign rsp_entry_valid  = entry_valid_ff;
   assign rsp_entry_id     = entry_valid_ff ? rd_id_ff : '0;
   assign rsp_entry_bytes  = entry_valid_ff ? rd_bytes_ff : '0;
   assign rsp_entry_age    = entry_valid_ff ? age_ext[wvwm_pkg::AGE_W-1:0] : '0;
   assign rsp_entry_reason = entry_valid_ff ? rd_reason_ff : '0;

endmodule
`default_nettype wire

// File: sv/wvwm_checker.sv
// Port-level checker for the write volume window monitor, with its bind.
`default_nettype none
module wvwm_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic                               rsp_logged,
   input wire logic                               rsp_alert,
   input wire logic [wvwm_pkg::COUNT_W-1:0]       rsp_transfers,
   input wire logic                               rsp_entry_valid,
   input wire logic [wvwm_pkg::COUNT_W-1:0]       rsp_entry_id,
   input wire logic [wvwm_pkg::BYTES_W-1:0]       rsp_entry_bytes,
   input wire logic [wvwm_pkg::AGE_W-1:0]         rsp_entry_age,
   input wire logic [wvwm_pkg::REASON_W-1:0]      rsp_entry_reason
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_transfers))
      else $error("stalled item changed or dropped");

   a_alert_needs_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alert |-> rsp_logged)
      else $error("alert without a logged event");

   a_read_not_logged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid |-> !rsp_logged)
      else $error("log read also recorded an event");

   a_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_entry_id == '0 && rsp_entry_bytes == '0 &&
                                        rsp_entry_age == '0 && rsp_entry_reason == '0)
      else $error("entry fields set without a valid entry");

endmodule

bind write_volume_window_monitor wvwm_checker u_wvwm_checker (.*);
`default_nettype wire
